>>> rtl/lbmeq_pkg.sv
package lbmeq_pkg;

    // number format
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // divider latency, input register to output register
    localparam int DIV_LAT = DATA_WIDTH + 2;

    typedef logic signed [DATA_WIDTH-1:0]   t_word;
    typedef logic signed [2*DATA_WIDTH-1:0] t_wide;
    typedef logic [DATA_WIDTH-2:0]          t_uword;

    typedef struct packed {
        t_word height;
        t_word vel_x;
        t_word vel_y;
    } t_in_item;

    typedef struct packed {
        t_word eq_value;
        logic  overflow;
    } t_result;

    // saturated value with its overflow flag
    typedef struct packed {
        logic  ovf;
        t_word val;
    } t_sat;

    // register indexes of the configuration channel
    typedef enum logic [2:0] {
        CFG_GRAVITY = 3'd0,
        CFG_SPEED   = 3'd1,
        CFG_CLASS   = 3'd2,
        CFG_DIR_X   = 3'd3,
        CFG_DIR_Y   = 3'd4
    } t_cfg_reg;

    localparam logic [1:0] CLASS_REST = 2'd0;
    localparam logic [1:0] CLASS_ODD  = 2'd1;

    localparam t_uword GRAVITY_RST = t_uword'(642908);
    localparam t_uword SPEED_RST   = t_uword'(65536);

    // scale factors of the equilibrium terms
    localparam t_wide K_REST_GH = 5;
    localparam t_wide K_REST_H  = 2;
    localparam t_wide K1_ODD    = 6;
    localparam t_wide K2_ODD    = 3;
    localparam t_wide K3_ODD    = 2;
    localparam t_wide K1_EVEN   = 24;
    localparam t_wide K2_EVEN   = 12;
    localparam t_wide K3_EVEN   = 8;

    localparam t_wide WMAX = {{(DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam t_wide WMIN = {{(DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

    // configuration as seen by the datapath
    typedef struct packed {
        logic   rest;
        t_uword gravity;
        t_uword speed;
        t_word  dir_x;
        t_word  dir_y;
        t_uword div_a;
        t_uword div_b;
        t_uword div_c;
        logic   ovf_rest;
        logic   ovf_dir;
    } t_cfg_view;

    // per-cell values carried alongside the dividers
    typedef struct packed {
        t_word h;
        t_word s;
        t_word cu;
        t_word cu2;
        logic  ovf_c;
        logic  ovf_r;
        logic  ovf_o;
    } t_carry;

    function automatic t_wide wide_of(input t_word x);
        return {{DATA_WIDTH{x[DATA_WIDTH-1]}}, x};
    endfunction

    function automatic t_wide uwide_of(input t_uword x);
        return {{(DATA_WIDTH+1){1'b0}}, x};
    endfunction

    function automatic t_sat sat_wide(input t_wide x);
        t_sat r;
        r.ovf = 1'b0;
        r.val = x[DATA_WIDTH-1:0];
        if (x > WMAX) begin
            r.ovf = 1'b1;
            r.val = WMAX[DATA_WIDTH-1:0];
        end else if (x < WMIN) begin
            r.ovf = 1'b1;
            r.val = WMIN[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    // fixed-point product scaling, truncated toward zero, then saturated
    function automatic t_sat fmul_post(input t_wide p);
        t_wide q;
        q = p >>> FRAC_BITS;
        if (p[2*DATA_WIDTH-1] && (p[FRAC_BITS-1:0] != '0)) begin
            q = q + t_wide'(1);
        end
        return sat_wide(q);
    endfunction

endpackage

>>> rtl/lbmeq_cfg.sv
module lbmeq_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [2:0]            i_index,
    input  lbmeq_pkg::t_word      i_data,
    output lbmeq_pkg::t_cfg_view  o_view
);

    localparam int W = lbmeq_pkg::DATA_WIDTH;

    logic [W-2:0]      r_gravity;
    logic [W-2:0]      r_speed;
    logic [1:0]        r_class;
    lbmeq_pkg::t_word  r_dir_x;
    lbmeq_pkg::t_word  r_dir_y;

    lbmeq_pkg::t_wide  r_ee_p;
    lbmeq_pkg::t_sat   r_ee;
    lbmeq_pkg::t_sat   r_div_a;
    lbmeq_pkg::t_sat   r_div_b;
    lbmeq_pkg::t_sat   r_div_c;

    lbmeq_pkg::t_wide  k1;
    lbmeq_pkg::t_wide  k2;
    lbmeq_pkg::t_wide  k3;
    lbmeq_pkg::t_wide  e_wide;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= lbmeq_pkg::GRAVITY_RST;
            r_speed   <= lbmeq_pkg::SPEED_RST;
            r_class   <= lbmeq_pkg::CLASS_REST;
            r_dir_x   <= '0;
            r_dir_y   <= '0;
        end else if (i_wr) begin
            unique case (i_index)
                lbmeq_pkg::CFG_GRAVITY: r_gravity <= i_data[W-2:0];
                lbmeq_pkg::CFG_SPEED:   r_speed   <= i_data[W-2:0];
                lbmeq_pkg::CFG_CLASS:   r_class   <= i_data[1:0];
                lbmeq_pkg::CFG_DIR_X:   r_dir_x   <= i_data;
                lbmeq_pkg::CFG_DIR_Y:   r_dir_y   <= i_data;
                default: ;
            endcase
        end
    end

    // scale factors of the selected direction class
    always_comb begin
        if (r_class == lbmeq_pkg::CLASS_REST || r_class == lbmeq_pkg::CLASS_ODD) begin
            k1 = lbmeq_pkg::K1_ODD;
            k2 = lbmeq_pkg::K2_ODD;
            k3 = lbmeq_pkg::K3_ODD;
        end else begin
            k1 = lbmeq_pkg::K1_EVEN;
            k2 = lbmeq_pkg::K2_EVEN;
            k3 = lbmeq_pkg::K3_EVEN;
        end
    end

    assign e_wide = lbmeq_pkg::uwide_of(r_speed);

    // divisors, registered from the configuration registers (div_c through r_ee_p and r_ee)
    always_ff @(posedge i_clk) begin
        r_ee_p  <= e_wide * e_wide;
        r_ee    <= lbmeq_pkg::fmul_post(r_ee_p);
        r_div_a <= lbmeq_pkg::sat_wide(e_wide * k1);
        r_div_b <= lbmeq_pkg::sat_wide(e_wide * k2);
        r_div_c <= lbmeq_pkg::sat_wide(lbmeq_pkg::wide_of(r_ee.val) * k3);
    end

    always_comb begin
        o_view.rest     = (r_class == lbmeq_pkg::CLASS_REST);
        o_view.gravity  = r_gravity;
        o_view.speed    = r_speed;
        o_view.dir_x    = r_dir_x;
        o_view.dir_y    = r_dir_y;
        o_view.div_a    = r_div_a.val[W-2:0];
        o_view.div_b    = r_div_b.val[W-2:0];
        o_view.div_c    = r_div_c.val[W-2:0];
        o_view.ovf_rest = r_div_a.ovf | r_div_b.ovf;
        o_view.ovf_dir  = r_div_a.ovf | r_div_b.ovf | r_ee.ovf | r_div_c.ovf;
    end

endmodule

>>> rtl/lbmeq_front.sv
module lbmeq_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  lbmeq_pkg::t_in_item   i_item,
    input  lbmeq_pkg::t_cfg_view  i_cfg,
    output logic                  o_valid,
    output lbmeq_pkg::t_carry     o_carry,
    output lbmeq_pkg::t_word      o_num_a,
    output lbmeq_pkg::t_word      o_num_b
);

    logic              r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;

    lbmeq_pkg::t_word  r_s1_h;
    lbmeq_pkg::t_wide  r_s1_hh, r_s1_uu, r_s1_vv, r_s1_xu, r_s1_yv;

    lbmeq_pkg::t_word  r_s2_h, r_s2_h2, r_s2_uu, r_s2_vv, r_s2_xu, r_s2_yv;
    logic              r_s2_oc, r_s2_oo;

    lbmeq_pkg::t_word  r_s3_h, r_s3_s, r_s3_cu;
    lbmeq_pkg::t_wide  r_s3_gh;
    logic              r_s3_oc, r_s3_oo;

    lbmeq_pkg::t_word  r_s4_h, r_s4_s, r_s4_cu, r_s4_ghs;
    lbmeq_pkg::t_wide  r_s4_cu2;
    logic              r_s4_oc, r_s4_oo;

    lbmeq_pkg::t_carry r_s5_c;
    lbmeq_pkg::t_word  r_s5_na, r_s5_nb;

    lbmeq_pkg::t_sat   s2_h2, s2_uu, s2_vv, s2_xu, s2_yv;
    lbmeq_pkg::t_sat   s3_s, s3_cu, s4_ghs, s5_cu2, s5_gh5, s5_h2x;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
        end
    end

    // stage 1: raw squares and direction products
    always_ff @(posedge i_clk) begin
        r_s1_h  <= i_item.height;
        r_s1_hh <= lbmeq_pkg::t_wide'(i_item.height) * lbmeq_pkg::t_wide'(i_item.height);
        r_s1_uu <= lbmeq_pkg::t_wide'(i_item.vel_x) * lbmeq_pkg::t_wide'(i_item.vel_x);
        r_s1_vv <= lbmeq_pkg::t_wide'(i_item.vel_y) * lbmeq_pkg::t_wide'(i_item.vel_y);
        r_s1_xu <= lbmeq_pkg::t_wide'(i_cfg.dir_x) * lbmeq_pkg::t_wide'(i_item.vel_x);
        r_s1_yv <= lbmeq_pkg::t_wide'(i_cfg.dir_y) * lbmeq_pkg::t_wide'(i_item.vel_y);
    end

    // stage 2: scale products
    always_comb begin
        s2_h2 = lbmeq_pkg::fmul_post(r_s1_hh);
        s2_uu = lbmeq_pkg::fmul_post(r_s1_uu);
        s2_vv = lbmeq_pkg::fmul_post(r_s1_vv);
        s2_xu = lbmeq_pkg::fmul_post(r_s1_xu);
        s2_yv = lbmeq_pkg::fmul_post(r_s1_yv);
    end

    always_ff @(posedge i_clk) begin
        r_s2_h  <= r_s1_h;
        r_s2_h2 <= s2_h2.val;
        r_s2_uu <= s2_uu.val;
        r_s2_vv <= s2_vv.val;
        r_s2_xu <= s2_xu.val;
        r_s2_yv <= s2_yv.val;
        r_s2_oc <= s2_h2.ovf | s2_uu.ovf | s2_vv.ovf;
        r_s2_oo <= s2_xu.ovf | s2_yv.ovf;
    end

    // stage 3: speed sums and gravity product
    always_comb begin
        s3_s  = lbmeq_pkg::sat_wide(lbmeq_pkg::wide_of(r_s2_uu) + lbmeq_pkg::wide_of(r_s2_vv));
        s3_cu = lbmeq_pkg::sat_wide(lbmeq_pkg::wide_of(r_s2_xu) + lbmeq_pkg::wide_of(r_s2_yv));
    end

    always_ff @(posedge i_clk) begin
        r_s3_h  <= r_s2_h;
        r_s3_s  <= s3_s.val;
        r_s3_cu <= s3_cu.val;
        r_s3_gh <= lbmeq_pkg::uwide_of(i_cfg.gravity) * lbmeq_pkg::wide_of(r_s2_h2);
        r_s3_oc <= r_s2_oc | s3_s.ovf;
        r_s3_oo <= r_s2_oo | s3_cu.ovf;
    end

    // stage 4: scale gravity term, square the projected velocity
    assign s4_ghs = lbmeq_pkg::fmul_post(r_s3_gh);

    always_ff @(posedge i_clk) begin
        r_s4_h   <= r_s3_h;
        r_s4_s   <= r_s3_s;
        r_s4_cu  <= r_s3_cu;
        r_s4_ghs <= s4_ghs.val;
        r_s4_cu2 <= lbmeq_pkg::t_wide'(r_s3_cu) * lbmeq_pkg::t_wide'(r_s3_cu);
        r_s4_oc  <= r_s3_oc | s4_ghs.ovf;
        r_s4_oo  <= r_s3_oo;
    end

    // stage 5: dividends for the divider lanes
    always_comb begin
        s5_cu2 = lbmeq_pkg::fmul_post(r_s4_cu2);
        s5_gh5 = lbmeq_pkg::sat_wide(lbmeq_pkg::wide_of(r_s4_ghs) * lbmeq_pkg::K_REST_GH);
        s5_h2x = lbmeq_pkg::sat_wide(lbmeq_pkg::wide_of(r_s4_h) * lbmeq_pkg::K_REST_H);
    end

    always_ff @(posedge i_clk) begin
        r_s5_c.h     <= r_s4_h;
        r_s5_c.s     <= r_s4_s;
        r_s5_c.cu    <= r_s4_cu;
        r_s5_c.cu2   <= s5_cu2.val;
        r_s5_c.ovf_c <= r_s4_oc;
        r_s5_c.ovf_r <= s5_gh5.ovf | s5_h2x.ovf;
        r_s5_c.ovf_o <= r_s4_oo | s5_cu2.ovf;
        r_s5_na      <= i_cfg.rest ? s5_gh5.val : r_s4_ghs;
        r_s5_nb      <= i_cfg.rest ? s5_h2x.val : r_s4_h;
    end

    assign o_valid = r_s5_v;
    assign o_carry = r_s5_c;
    assign o_num_a = r_s5_na;
    assign o_num_b = r_s5_nb;

endmodule

>>> rtl/lbmeq_div.sv
module lbmeq_div (
    input  logic              i_clk,
    input  lbmeq_pkg::t_word  i_num,
    input  lbmeq_pkg::t_uword i_den,
    output lbmeq_pkg::t_sat   o_quot
);

    localparam int W  = lbmeq_pkg::DATA_WIDTH;
    localparam int F  = lbmeq_pkg::FRAC_BITS;
    localparam int SH = W - F;

    typedef struct packed {
        logic neg;
        logic nz;
        logic big;
        logic zero;
    } t_dflag;

    logic [W-1:0]   num_u;
    logic [W-1:0]   mag;
    logic [2*W-1:0] mag_x;
    logic [2*W-1:0] den_x;

    logic [W-1:0]   r_rem [0:W];
    logic [W-1:0]   r_sh  [0:W];
    logic [W-1:0]   r_q   [0:W];
    t_dflag         r_f   [0:W];

    lbmeq_pkg::t_sat r_out;
    lbmeq_pkg::t_sat res;
    logic [W-1:0]    q_fin;

    // magnitude and quotient range check
    always_comb begin
        num_u = i_num;
        mag   = num_u[W-1] ? (~num_u + {{(W-1){1'b0}}, 1'b1}) : num_u;
        mag_x = {{W{1'b0}}, mag};
        den_x = {{(W+1){1'b0}}, i_den} << SH;
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]    <= {{SH{1'b0}}, mag[W-1:SH]};
        r_sh[0]     <= {mag[SH-1:0], {F{1'b0}}};
        r_q[0]      <= '0;
        r_f[0].neg  <= num_u[W-1];
        r_f[0].nz   <= (num_u != '0);
        r_f[0].big  <= (mag_x >= den_x);
        r_f[0].zero <= (i_den == '0);
    end

    // one quotient bit per stage
    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W-1:0] trial;
        logic         fits;

        always_comb begin
            trial = {r_rem[k][W-2:0], r_sh[k][W-1]};
            fits  = (trial >= {1'b0, i_den});
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= fits ? (trial - {1'b0, i_den}) : trial;
            r_sh[k+1]  <= {r_sh[k][W-2:0], 1'b0};
            r_q[k+1]   <= {r_q[k][W-2:0], fits};
            r_f[k+1]   <= r_f[k];
        end
    end

    // sign, saturation and zero divisor
    always_comb begin
        q_fin   = r_q[W];
        res.ovf = 1'b0;
        res.val = lbmeq_pkg::t_word'(q_fin);
        if (r_f[W].zero) begin
            res.ovf = 1'b1;
            if (!r_f[W].nz) begin
                res.val = '0;
            end else if (r_f[W].neg) begin
                res.val = lbmeq_pkg::WMIN[W-1:0];
            end else begin
                res.val = lbmeq_pkg::WMAX[W-1:0];
            end
        end else if (r_f[W].big) begin
            res.ovf = 1'b1;
            res.val = r_f[W].neg ? lbmeq_pkg::WMIN[W-1:0] : lbmeq_pkg::WMAX[W-1:0];
        end else if (r_f[W].neg) begin
            if (q_fin > {1'b1, {(W-1){1'b0}}}) begin
                res.ovf = 1'b1;
                res.val = lbmeq_pkg::WMIN[W-1:0];
            end else begin
                res.val = lbmeq_pkg::t_word'(~q_fin + {{(W-1){1'b0}}, 1'b1});
            end
        end else if (q_fin > {1'b0, {(W-1){1'b1}}}) begin
            res.ovf = 1'b1;
            res.val = lbmeq_pkg::WMAX[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= res;
    end

    assign o_quot = r_out;

endmodule

>>> rtl/lbmeq_back.sv
module lbmeq_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  lbmeq_pkg::t_carry     i_carry,
    input  lbmeq_pkg::t_sat       i_qa,
    input  lbmeq_pkg::t_sat       i_qb,
    input  lbmeq_pkg::t_sat       i_qc,
    input  lbmeq_pkg::t_sat       i_qd,
    input  lbmeq_pkg::t_cfg_view  i_cfg,
    output logic                  o_valid,
    output lbmeq_pkg::t_result    o_res
);

    logic              r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;

    lbmeq_pkg::t_word  r_s1_h, r_s1_t1;
    lbmeq_pkg::t_wide  r_s1_p2, r_s1_p3, r_s1_p4;
    logic              r_s1_oc, r_s1_or, r_s1_oo;

    lbmeq_pkg::t_word  r_s2_h, r_s2_t1, r_s2_t2, r_s2_t3, r_s2_t4;
    logic              r_s2_oc, r_s2_or, r_s2_oo;

    lbmeq_pkg::t_word  r_s3_a, r_s3_t2, r_s3_t3, r_s3_t4;
    logic              r_s3_oc, r_s3_or, r_s3_oo;

    lbmeq_pkg::t_word  r_s4_b, r_s4_t4;
    logic              r_s4_oc, r_s4_or, r_s4_oo;

    lbmeq_pkg::t_result r_s5_res;

    lbmeq_pkg::t_sat   s2_t2, s2_t3, s2_t4, s3_a, s4_b, s5_f;
    lbmeq_pkg::t_word  s1_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
        end
    end

    // stage 1: quotients times velocity terms
    assign s1_m2 = i_cfg.rest ? i_carry.s : i_carry.cu;

    always_ff @(posedge i_clk) begin
        r_s1_h  <= i_carry.h;
        r_s1_t1 <= i_qa.val;
        r_s1_p2 <= lbmeq_pkg::t_wide'(i_qb.val) * lbmeq_pkg::t_wide'(s1_m2);
        r_s1_p3 <= lbmeq_pkg::t_wide'(i_qc.val) * lbmeq_pkg::t_wide'(i_carry.cu2);
        r_s1_p4 <= lbmeq_pkg::t_wide'(i_qd.val) * lbmeq_pkg::t_wide'(i_carry.s);
        r_s1_oc <= i_carry.ovf_c | i_qa.ovf | i_qb.ovf;
        r_s1_or <= i_carry.ovf_r;
        r_s1_oo <= i_carry.ovf_o | i_qc.ovf | i_qd.ovf;
    end

    // stage 2: scale products
    always_comb begin
        s2_t2 = lbmeq_pkg::fmul_post(r_s1_p2);
        s2_t3 = lbmeq_pkg::fmul_post(r_s1_p3);
        s2_t4 = lbmeq_pkg::fmul_post(r_s1_p4);
    end

    always_ff @(posedge i_clk) begin
        r_s2_h  <= r_s1_h;
        r_s2_t1 <= r_s1_t1;
        r_s2_t2 <= s2_t2.val;
        r_s2_t3 <= s2_t3.val;
        r_s2_t4 <= s2_t4.val;
        r_s2_oc <= r_s1_oc | s2_t2.ovf;
        r_s2_or <= r_s1_or;
        r_s2_oo <= r_s1_oo | s2_t3.ovf | s2_t4.ovf;
    end

    // stage 3: first sum, or first difference in rest mode; zero when no item is valid
    assign s3_a = r_s2_v ? (i_cfg.rest
        ? lbmeq_pkg::sat_wide(lbmeq_pkg::wide_of(r_s2_h) - lbmeq_pkg::wide_of(r_s2_t1))
        : lbmeq_pkg::sat_wide(lbmeq_pkg::wide_of(r_s2_t1) + lbmeq_pkg::wide_of(r_s2_t2)))
        : '0;

    always_ff @(posedge i_clk) begin
        r_s3_a  <= s3_a.val;
        r_s3_t2 <= r_s2_t2;
        r_s3_t3 <= r_s2_t3;
        r_s3_t4 <= r_s2_t4;
        r_s3_oc <= r_s2_oc | s3_a.ovf;
        r_s3_or <= r_s2_or;
        r_s3_oo <= r_s2_oo;
    end

    // stage 4: second sum, or second difference in rest mode
    assign s4_b = i_cfg.rest
        ? lbmeq_pkg::sat_wide(lbmeq_pkg::wide_of(r_s3_a) - lbmeq_pkg::wide_of(r_s3_t2))
        : lbmeq_pkg::sat_wide(lbmeq_pkg::wide_of(r_s3_a) + lbmeq_pkg::wide_of(r_s3_t3));

    always_ff @(posedge i_clk) begin
        r_s4_b  <= s4_b.val;
        r_s4_t4 <= r_s3_t4;
        r_s4_oc <= r_s3_oc | s4_b.ovf;
        r_s4_or <= r_s3_or;
        r_s4_oo <= r_s3_oo;
    end

    // stage 5: last difference for non-rest classes, overflow merge for all
    assign s5_f = lbmeq_pkg::sat_wide(lbmeq_pkg::wide_of(r_s4_b) - lbmeq_pkg::wide_of(r_s4_t4));

    always_ff @(posedge i_clk) begin
        if (i_cfg.rest) begin
            r_s5_res.eq_value <= r_s4_b;
            r_s5_res.overflow <= r_s4_oc | r_s4_or | i_cfg.ovf_rest;
        end else begin
            r_s5_res.eq_value <= s5_f.val;
            r_s5_res.overflow <= r_s4_oc | r_s4_oo | s5_f.ovf | i_cfg.ovf_dir;
        end
    end

    assign o_valid = r_s5_v;
    assign o_res   = r_s5_res;

endmodule

>>> rtl/lbm_shallow_water_equilibrium_top.sv
// Shallow-water lattice Boltzmann equilibrium, one grid cell per transaction.
// Input channel: a cell (height, vel_x, vel_y) is taken at a rising edge with
// start high and busy low. busy never rises, so a cell may enter every cycle.
// Result channel: o_res_valid marks o_res for exactly one cycle; the receiver
// cannot hold results off and none are buffered.
// Throughput: one cell per cycle. The latency is set by the four restoring
// dividers, one quotient bit per stage, plus five stages before and five
// after them.
// Configuration channel: i_cfg_valid with o_cfg_ready (always high), register
// index and data; unknown indexes are ignored. The user must write only while
// no cell is in flight; the block does not enforce it. Derived divisors settle
// in their registers before any newly accepted cell reaches the dividers.
// Reset (synchronous, active low) loads the register defaults and clears all
// valid bits, dropping any cell in flight. Overflow flags any saturated step
// and a zero divisor.
module lbm_shallow_water_equilibrium_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  lbmeq_pkg::t_in_item  i_item,
    output logic                 o_res_valid,
    output lbmeq_pkg::t_result   o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  lbmeq_pkg::t_word     i_cfg_data
);

    localparam int LATENCY = lbmeq_pkg::DATA_WIDTH + 12;
    localparam int DL      = lbmeq_pkg::DIV_LAT;

    lbmeq_pkg::t_cfg_view w_cfg;
    logic                 w_accept;
    logic                 w_fr_v;
    lbmeq_pkg::t_carry    w_fr_c;
    lbmeq_pkg::t_word     w_num_a, w_num_b;
    lbmeq_pkg::t_sat      w_qa, w_qb, w_qc, w_qd;

    logic                 r_dly_v [0:DL-1];
    lbmeq_pkg::t_carry    r_dly   [0:DL-1];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;

    lbmeq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid & o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_view  (w_cfg)
    );

    lbmeq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_item  (i_item),
        .i_cfg   (w_cfg),
        .o_valid (w_fr_v),
        .o_carry (w_fr_c),
        .o_num_a (w_num_a),
        .o_num_b (w_num_b)
    );

    // divider lanes
    lbmeq_div u_div_a (.i_clk(i_clk), .i_num(w_num_a),  .i_den(w_cfg.div_a), .o_quot(w_qa));
    lbmeq_div u_div_b (.i_clk(i_clk), .i_num(w_num_b),  .i_den(w_cfg.div_b), .o_quot(w_qb));
    lbmeq_div u_div_c (.i_clk(i_clk), .i_num(w_fr_c.h), .i_den(w_cfg.div_c), .o_quot(w_qc));
    lbmeq_div u_div_d (.i_clk(i_clk), .i_num(w_fr_c.h), .i_den(w_cfg.div_a), .o_quot(w_qd));

    // carried values aligned with the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DL; i++) begin
                r_dly_v[i] <= 1'b0;
            end
        end else begin
            r_dly_v[0] <= w_fr_v;
            for (int i = 1; i < DL; i++) begin
                r_dly_v[i] <= r_dly_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dly[0] <= w_fr_c;
        for (int i = 1; i < DL; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    lbmeq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_dly_v[DL-1]),
        .i_carry (r_dly[DL-1]),
        .i_qa    (w_qa),
        .i_qb    (w_qb),
        .i_qc    (w_qc),
        .i_qd    (w_qd),
        .i_cfg   (w_cfg),
        .o_valid (o_res_valid),
        .o_res   (o_res)
    );

    // every accepted cell yields a result on o_res_valid
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##LATENCY o_res_valid)
        else $error("result missing after accepted cell");

    // no result on o_res_valid without a matching accepted cell
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(w_accept, LATENCY))
        else $error("result without accepted cell");

    // zero lattice speed term always flags overflow
    a_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && w_cfg.speed == '0) |-> o_res.overflow)
        else $error("zero divisor not flagged");

endmodule
